// ===== sv/mvrc_pkg.sv =====
// ----------------------------------------------------------------------------
// mvrc_pkg
// Shared types, register indexes and tables for the motion vector rate cost.
// ----------------------------------------------------------------------------
package mvrc_pkg;

   // Result width and configuration port widths
   localparam int OUT_W     = 22;
   localparam int LAMBDA_W  = 16;
   localparam int RANGE_W   = 8;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LAMBDA_WEIGHT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SEARCH_RANGE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CODEC_MODE    = 2'd2;

   // Codec mode codes
   localparam logic MODE_MPEG4 = 1'b0;
   localparam logic MODE_H264  = 1'b1;

   // Reset values
   localparam logic [LAMBDA_W-1:0] LAMBDA_RST = 16'd0;
   localparam logic [RANGE_W-1:0]  RANGE_RST  = 8'd16;
   localparam logic                MODE_RST   = MODE_H264;

   // Configuration as seen by the datapath
   typedef struct packed {
      logic [LAMBDA_W-1:0] lambda_weight;
      logic [1:0]          f_extra;     // f_code - 1
      logic                codec_mode;
   } cfg_type;

   // f_code - 1 from the search range
   function automatic logic [1:0] f_extra_of(input logic [RANGE_W-1:0] range);
      logic [1:0] f;
      if (range <= 8'd16) begin
         f = 2'd0;
      end else if (range <= 8'd32) begin
         f = 2'd1;
      end else begin
         f = 2'd2;
      end
      return f;
   endfunction

   // MPEG-4 threshold table on the normalised magnitude (clamped to 31)
   function automatic logic [3:0] mp4_base(input logic [4:0] n);
      logic [3:0] b;
      case (n) inside
         5'd1:           b = 4'd3;
         5'd2:           b = 4'd4;
         5'd3:           b = 4'd5;
         5'd4:           b = 4'd7;
         [5'd5:5'd7]:    b = 4'd8;
         [5'd8:5'd10]:   b = 4'd10;
         [5'd11:5'd24]:  b = 4'd11;
         [5'd25:5'd30]:  b = 4'd12;
         default:        b = 4'd13;
      endcase
      return b;
   endfunction

endpackage

// ===== sv/mvrc_csr.sv =====
// ----------------------------------------------------------------------------
// mvrc_csr
// Configuration registers: lambda weight, search range and codec mode.
// ----------------------------------------------------------------------------
module mvrc_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [mvrc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mvrc_pkg::CSR_DAT_W-1:0]     csr_wdata,
   output mvrc_pkg::cfg_type                  cfg
);
   import mvrc_pkg::*;

   logic [LAMBDA_W-1:0] lambda_weight_ff;
   logic [RANGE_W-1:0]  search_range_ff;
   logic                codec_mode_ff;
   logic                wr_en;

   // Writes are always taken
   assign csr_ready = 1'b1;
   assign wr_en     = csr_valid & csr_ready;

   // Register file; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         lambda_weight_ff <= LAMBDA_RST;
         search_range_ff  <= RANGE_RST;
         codec_mode_ff    <= MODE_RST;
      end else if (wr_en) begin
         unique case (csr_index)
            CSR_LAMBDA_WEIGHT: lambda_weight_ff <= csr_wdata[LAMBDA_W-1:0];
            CSR_SEARCH_RANGE:  search_range_ff  <= csr_wdata[RANGE_W-1:0];
            CSR_CODEC_MODE:    codec_mode_ff    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign cfg.lambda_weight = lambda_weight_ff;
   assign cfg.f_extra       = f_extra_of(search_range_ff);
   assign cfg.codec_mode    = codec_mode_ff;

endmodule

// ===== sv/mvrc_bits.sv =====
// ----------------------------------------------------------------------------
// mvrc_bits
// Bit estimate for one vector difference component, H.264 or MPEG-4 style.
// ----------------------------------------------------------------------------
module mvrc_bits #(
   parameter int DIFF_W = 15,
   parameter int BITS_W = 5
) (
   input  logic [DIFF_W-1:0]  diff,      // two's complement
   input  mvrc_pkg::cfg_type  cfg,
   output logic [BITS_W-1:0]  bits
);
   import mvrc_pkg::*;

   localparam int LEN_W = $clog2(DIFF_W + 1);

   logic [DIFF_W-1:0] abs_d;
   logic [LEN_W-1:0]  len;
   logic [BITS_W-1:0] eg_bits;
   logic [DIFF_W-1:0] half;
   logic [DIFF_W-1:0] mag;
   logic [DIFF_W-1:0] norm;
   logic [4:0]        norm_sat;
   logic [BITS_W-1:0] mp4_bits;

   // Exp-Golomb: length is 2 * bit length of |d| + 1
   assign abs_d = diff[DIFF_W-1] ? (~diff + DIFF_W'(1)) : diff;

   always_comb begin
      len = '0;
      for (int i = 0; i < DIFF_W; i++) begin
         if (abs_d[i]) len = LEN_W'(i + 1);
      end
   end

   assign eg_bits = BITS_W'({len, 1'b1});

   // MPEG-4: halve (floor), normalise by magnitude band, then table plus f_code - 1
   assign half = {diff[DIFF_W-1], diff[DIFF_W-1:1]};
   assign mag  = half[DIFF_W-1] ? (~half + DIFF_W'(1)) : half;

   always_comb begin
      if (mag <= DIFF_W'(32)) begin
         norm = mag;
      end else if (mag <= DIFF_W'(64)) begin
         norm = mag >> 1;
      end else begin
         norm = mag >> 2;
      end
   end

   assign norm_sat = (norm > DIFF_W'(31)) ? 5'd31 : norm[4:0];
   assign mp4_bits = (half == '0) ? BITS_W'(1)
                   : BITS_W'(mp4_base(norm_sat)) + BITS_W'(cfg.f_extra);

   assign bits = (cfg.codec_mode == MODE_H264) ? eg_bits : mp4_bits;

endmodule

// ===== sv/motion_vector_rate_cost.sv =====
// ----------------------------------------------------------------------------
// motion_vector_rate_cost
// Rate cost lambda * (bits_x + bits_y) of a motion vector difference.
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  req      in         req_valid / req_ready  cand_x, cand_y, pred_x, pred_y
//  rsp      out        rsp_valid / rsp_ready  rate_cost
//  csr      in         csr_valid / csr_ready  csr_index, csr_wdata
//
//  One item per cycle unless the result stalls; a result passes the input
//  register, then the result register holding the estimate and the multiply.
//  Reset empties both stages and loads the register reset values; csr is
//  always ready. A stalled result holds the result register, and the input
//  register keeps taking items as long as the result register can drain.
// ----------------------------------------------------------------------------
module motion_vector_rate_cost #(
   parameter int MV_WIDTH = 14
) (
   input  logic                            clock,
   input  logic                            reset,
   // request
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [MV_WIDTH-1:0]             req_cand_x,
   input  logic [MV_WIDTH-1:0]             req_cand_y,
   input  logic [MV_WIDTH-1:0]             req_pred_x,
   input  logic [MV_WIDTH-1:0]             req_pred_y,
   // response
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [mvrc_pkg::OUT_W-1:0]      rsp_rate_cost,
   // configuration
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [mvrc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mvrc_pkg::CSR_DAT_W-1:0]  csr_wdata
);
   import mvrc_pkg::*;

   localparam int DIFF_W = MV_WIDTH + 1;
   localparam int BITS_W = $clog2(2 * MV_WIDTH + 4);
   localparam int SUM_W  = BITS_W + 1;
   localparam int PROD_W = LAMBDA_W + SUM_W;

   cfg_type cfg;

   logic                s1_valid_ff;
   logic [MV_WIDTH-1:0] cand_x_ff, cand_y_ff, pred_x_ff, pred_y_ff;
   logic                rsp_valid_ff;
   logic [OUT_W-1:0]    rate_cost_ff, rate_cost_in;

   logic                out_free;
   logic                s1_adv;
   logic                req_take;
   logic [DIFF_W-1:0]   diff_x, diff_y;
   logic [BITS_W-1:0]   bits_x, bits_y;
   logic [SUM_W-1:0]    bits_sum;
   logic [PROD_W-1:0]   product;

   // Configuration registers
   mvrc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Flow control
   assign out_free  = ~rsp_valid_ff | rsp_ready;
   assign s1_adv    = s1_valid_ff & out_free;
   assign req_ready = ~s1_valid_ff | out_free;
   assign req_take  = req_valid & req_ready;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         cand_x_ff <= req_cand_x;
         cand_y_ff <= req_cand_y;
         pred_x_ff <= req_pred_x;
         pred_y_ff <= req_pred_y;
      end
   end

   // Differences, sign extended by one bit
   assign diff_x = {cand_x_ff[MV_WIDTH-1], cand_x_ff} - {pred_x_ff[MV_WIDTH-1], pred_x_ff};
   assign diff_y = {cand_y_ff[MV_WIDTH-1], cand_y_ff} - {pred_y_ff[MV_WIDTH-1], pred_y_ff};

   // Per-axis bit estimates
   mvrc_bits #(.DIFF_W(DIFF_W), .BITS_W(BITS_W)) u_bits_x (
      .diff (diff_x),
      .cfg  (cfg),
      .bits (bits_x)
   );

   mvrc_bits #(.DIFF_W(DIFF_W), .BITS_W(BITS_W)) u_bits_y (
      .diff (diff_y),
      .cfg  (cfg),
      .bits (bits_y)
   );

   // Weighted cost, kept to the result width
   assign bits_sum     = SUM_W'(bits_x) + SUM_W'(bits_y);
   assign product      = PROD_W'(cfg.lambda_weight) * PROD_W'(bits_sum);
   assign rate_cost_in = product[OUT_W-1:0];

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rate_cost_ff <= rate_cost_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_rate_cost = rate_cost_ff;

endmodule

// ===== sv/mvrc_check.sv =====
// ----------------------------------------------------------------------------
// mvrc_check
// Port-level checks on the rate cost block, bound to the top level.
// ----------------------------------------------------------------------------
module mvrc_check (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [mvrc_pkg::OUT_W-1:0]    rsp_rate_cost
);

   // A stalled result holds its value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_rate_cost))
      else $error("stalled result changed");

   // Reset leaves no result pending
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // An accepted item reaches the output once the output drains behind it
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) ##1 rsp_ready |=> rsp_valid)
      else $error("accepted item did not reach the output");

   // The input side keeps moving while the output is being drained
   assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("input stalled while output free");

endmodule

bind motion_vector_rate_cost mvrc_check u_mvrc_check (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_rate_cost (rsp_rate_cost)
);
